// ----- rtl/msatr_pkg.sv -----
// Shared constants, types and register indexes for the throttle ramp block.
package msatr_pkg;

   localparam int ADC_BITS_DEF      = 10;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int SAMPLE_W = 10;
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 24;
   localparam int DIV_W    = 16;
   localparam int LEVEL_W  = 10;
   localparam int DRIVE_W  = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_SLOW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_FAST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RISE_SLOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RISE_FAST   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FALL        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MIN     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MAX     = 3'd6;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   localparam logic [PERIOD_W-1:0] RST_PERIOD_SLOW = 24'd66666;
   localparam logic [PERIOD_W-1:0] RST_PERIOD_FAST = 24'd2409;
   localparam logic [DIV_W-1:0]    RST_RISE_SLOW   = 16'd300;
   localparam logic [DIV_W-1:0]    RST_RISE_FAST   = 16'd20;
   localparam logic [DIV_W-1:0]    RST_FALL        = 16'd1;
   localparam logic [LEVEL_W-1:0]  RST_OUT_MIN     = 10'd10;
   localparam logic [LEVEL_W-1:0]  RST_OUT_MAX     = 10'd800;

   localparam int QUEUE_DEPTH = 2;

   // classified tick carried from front to back
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [PERIOD_W-1:0] period;
   } tick_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period_slow;
      logic [PERIOD_W-1:0] period_fast;
      logic [DIV_W-1:0]    rise_slow;
      logic [DIV_W-1:0]    rise_fast;
      logic [DIV_W-1:0]    fall;
      logic [LEVEL_W-1:0]  out_min;
      logic [LEVEL_W-1:0]  out_max;
   } cfg_type;

endpackage

// ----- rtl/motor_speed_adaptive_throttle_ramp_top.sv -----
// Top level of the adaptive throttle ramp.
//  channel   ports                          direction
//  request   push/full + req_ fields            in
//  response  empty/pop + rsp_ fields            out
//  csr       csr_valid/csr_ready idx data   in
// A tick passes through the back end in two passes of the 42-bit serial divider (rise
// divisor, smoothing step) and a reciprocal level map (product, then offset and clamp);
// with equal periods the first pass is skipped. Reset is synchronous, clears the smoothed
// value and edge state, and sets the registers to their reset values. A full response
// queue stalls the back end; the front end keeps taking edges until its tick queue fills.
module motor_speed_adaptive_throttle_ramp_top #(
   parameter int ADC_BITS      = msatr_pkg::ADC_BITS_DEF,
   parameter int FRACTION_BITS = msatr_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic                              req_opcode,
   input  logic [msatr_pkg::SAMPLE_W-1:0]    req_throttle_sample,
   input  logic [msatr_pkg::TIME_W-1:0]      req_timestamp_us,
   output logic                              empty,
   input  logic                              pop,
   output logic [msatr_pkg::DRIVE_W-1:0]     rsp_drive_value,
   output logic [msatr_pkg::LEVEL_W-1:0]     rsp_mapped_level,
   output logic [msatr_pkg::DIV_W-1:0]       rsp_rise_divisor,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [msatr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [msatr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   localparam int TW = $bits(msatr_pkg::tick_type);
   localparam int RW = msatr_pkg::DRIVE_W + msatr_pkg::LEVEL_W + msatr_pkg::DIV_W;

   msatr_pkg::cfg_type  cfg_ff, cfg_in;
   msatr_pkg::tick_type f_tick, b_tick;
   logic in_ready, f_valid, f_ready, b_valid, b_ready, r_valid, r_ready, o_valid;
   logic [msatr_pkg::DRIVE_W-1:0] r_drive;
   logic [msatr_pkg::LEVEL_W-1:0] r_level;
   logic [msatr_pkg::DIV_W-1:0]   r_rise;
   logic [TW-1:0] b_bits;

   assign csr_ready = 1'b1;
   assign full  = !in_ready;
   assign empty = !o_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            msatr_pkg::REG_PERIOD_SLOW: cfg_in.period_slow = csr_wdata;
            msatr_pkg::REG_PERIOD_FAST: cfg_in.period_fast = csr_wdata;
            msatr_pkg::REG_RISE_SLOW:   cfg_in.rise_slow = csr_wdata[15:0];
            msatr_pkg::REG_RISE_FAST:   cfg_in.rise_fast = csr_wdata[15:0];
            msatr_pkg::REG_FALL:        cfg_in.fall      = csr_wdata[15:0];
            msatr_pkg::REG_OUT_MIN:     cfg_in.out_min   = csr_wdata[9:0];
            msatr_pkg::REG_OUT_MAX:     cfg_in.out_max   = csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{msatr_pkg::RST_PERIOD_SLOW, msatr_pkg::RST_PERIOD_FAST,
                     msatr_pkg::RST_RISE_SLOW, msatr_pkg::RST_RISE_FAST,
                     msatr_pkg::RST_FALL, msatr_pkg::RST_OUT_MIN,
                     msatr_pkg::RST_OUT_MAX};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msatr_front #(.ADC_BITS(ADC_BITS)) u_front (
      .clock, .reset, .in_valid(push), .in_ready,
      .opcode(req_opcode), .throttle_sample(req_throttle_sample),
      .timestamp_us(req_timestamp_us),
      .tick_valid(f_valid), .tick_ready(f_ready), .tick(f_tick));

   msatr_queue #(.WIDTH(TW)) u_tq (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_tick),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_bits));
   assign b_tick = b_bits;

   msatr_back #(.ADC_BITS(ADC_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock, .reset, .cfg(cfg_ff), .tick_valid(b_valid), .tick_ready(b_ready),
      .tick(b_tick), .res_valid(r_valid), .res_ready(r_ready),
      .res_drive(r_drive), .res_level(r_level), .res_rise(r_rise));

   msatr_queue #(.WIDTH(RW)) u_rq (
      .clock, .reset, .wr_valid(r_valid), .wr_ready(r_ready),
      .wr_data({r_drive, r_level, r_rise}),
      .rd_valid(o_valid), .rd_ready(pop),
      .rd_data({rsp_drive_value, rsp_mapped_level, rsp_rise_divisor}));
endmodule

// ----- rtl/msatr_front.sv -----
// Front end: edge timing and classification of ticks into the queue.
module msatr_front #(
   parameter int ADC_BITS = msatr_pkg::ADC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic                            opcode,
   input  logic [msatr_pkg::SAMPLE_W-1:0]  throttle_sample,
   input  logic [msatr_pkg::TIME_W-1:0]    timestamp_us,
   output logic                            tick_valid,
   input  logic                            tick_ready,
   output msatr_pkg::tick_type             tick
);
   // sample bits that carry the converter reading
   localparam int KEEP_W = (ADC_BITS < msatr_pkg::SAMPLE_W) ? ADC_BITS : msatr_pkg::SAMPLE_W;

   logic                          waiting_ff, waiting_in;
   logic [msatr_pkg::TIME_W-1:0]  first_ff, first_in;
   logic [msatr_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [msatr_pkg::TIME_W-1:0]  diff;

   assign in_ready   = tick_ready;
   assign tick_valid = in_valid && (opcode == msatr_pkg::OP_TICK);
   assign tick.period = period_ff;
   assign tick.sample = msatr_pkg::SAMPLE_W'(throttle_sample[KEEP_W-1:0]);
   assign diff = timestamp_us - first_ff;

   always_comb begin
      waiting_in = waiting_ff;
      first_in   = first_ff;
      period_in  = period_ff;
      if (in_valid && in_ready && opcode == msatr_pkg::OP_EDGE) begin
         if (!waiting_ff) begin
            first_in   = timestamp_us;
            waiting_in = 1'b1;
         end else begin
            // period kept already saturated to 24 bits
            period_in  = (|diff[msatr_pkg::TIME_W-1:msatr_pkg::PERIOD_W]) ?
                         {msatr_pkg::PERIOD_W{1'b1}} : diff[msatr_pkg::PERIOD_W-1:0];
            waiting_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b0;
         first_ff   <= '0;
         period_ff  <= '0;
      end else begin
         waiting_ff <= waiting_in;
         first_ff   <= first_in;
         period_ff  <= period_in;
      end
   end
endmodule

// ----- rtl/msatr_queue.sv -----
// Small FIFO between front and back ends, also used for results.
module msatr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = msatr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [PW:0]      cnt_ff;
   logic             wr, rd;

   assign wr_ready = (cnt_ff != DEPTH[PW:0]);
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= (wp_ff == PW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (rd) rp_ff <= (rp_ff == PW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + {{PW{1'b0}}, wr} - {{PW{1'b0}}, rd};
      end
   end
endmodule

// ----- rtl/msatr_back.sv -----
// Back end: rise divisor, smoothing update and level map, with a shared serial divider.
module msatr_back #(
   parameter int ADC_BITS      = msatr_pkg::ADC_BITS_DEF,
   parameter int FRACTION_BITS = msatr_pkg::FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  msatr_pkg::cfg_type             cfg,
   input  logic                           tick_valid,
   output logic                           tick_ready,
   input  msatr_pkg::tick_type            tick,
   output logic                           res_valid,
   input  logic                           res_ready,
   output logic [msatr_pkg::DRIVE_W-1:0]  res_drive,
   output logic [msatr_pkg::LEVEL_W-1:0]  res_level,
   output logic [msatr_pkg::DIV_W-1:0]    res_rise
);
   localparam int ACC_W = ADC_BITS + FRACTION_BITS;
   // dividend magnitude width: covers 24x17 product and d*2^F
   localparam int NUM_W = (ACC_W + 1 > 42) ? ACC_W + 1 : 42;
   localparam int DEN_W = 25;
   localparam int CW    = $clog2(NUM_W + 1);
   localparam int SPAN  = (1 << ADC_BITS) - 2;
   // level map divides by SPAN with a rounded-up reciprocal, exact for LN_W-bit magnitudes
   localparam int LN_W  = ADC_BITS + msatr_pkg::LEVEL_W;
   localparam int RK    = LN_W + $clog2(SPAN);
   localparam int RM_W  = LN_W + 2;
   localparam logic [63:0] RECIP_WIDE = ((64'd1 << RK) + 64'(SPAN) - 64'd1) / 64'(SPAN);
   localparam logic [RM_W-1:0] RECIP = RECIP_WIDE[RM_W-1:0];
   localparam int PERIOD_W_S = msatr_pkg::PERIOD_W + 1;

   localparam logic [2:0] S_IDLE = 3'd0, S_RMUL = 3'd1, S_RDIV = 3'd2,
                          S_ADJ = 3'd3, S_ADIV = 3'd4, S_LMAP = 3'd5,
                          S_LDIV = 3'd6, S_OUT = 3'd7;

   logic [2:0]  st_ff, st_in;
   logic [msatr_pkg::SAMPLE_W-1:0]  smp_ff, smp_in;
   logic [msatr_pkg::PERIOD_W-1:0]  per_ff, per_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [msatr_pkg::DIV_W-1:0] rise_ff, rise_in;
   logic signed [18:0] t_ff, t_in;   // offset added after division
   logic        neg_ff, neg_in;
   // serial divider
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W:0]   r_sh, r_sub;
   // level registers
   logic [msatr_pkg::LEVEL_W-1:0] lvl_ff, lvl_in;

   // combinational helpers
   logic signed [PERIOD_W_S-1:0] dp, dpp;
   logic signed [msatr_pkg::DIV_W:0] dr;
   logic signed [PERIOD_W_S+msatr_pkg::DIV_W:0] prod;
   logic signed [NUM_W:0] qs, rsum;
   logic signed [ACC_W+1:0] diff;
   logic signed [ADC_BITS+1:0] dwhole;
   logic signed [ACC_W+2:0] newacc;
   logic signed [ADC_BITS:0] xm1;
   logic signed [msatr_pkg::LEVEL_W:0] span_o;
   logic signed [ADC_BITS+msatr_pkg::LEVEL_W+1:0] lprod;
   logic [LN_W+RM_W-1:0] lmul;
   logic [msatr_pkg::DIV_W-1:0] divsel;

   assign tick_ready = (st_ff == S_IDLE);
   assign res_valid  = (st_ff == S_OUT);
   assign res_level  = lvl_ff;
   assign res_drive  = {lvl_ff, 2'b00};
   assign res_rise   = rise_ff;

   assign r_sh  = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
   assign r_sub = r_sh - {1'b0, den_ff};

   assign dp   = $signed({1'b0, per_ff}) - $signed({1'b0, cfg.period_slow});
   assign dpp  = $signed({1'b0, cfg.period_fast}) - $signed({1'b0, cfg.period_slow});
   assign dr   = $signed({1'b0, cfg.rise_fast}) - $signed({1'b0, cfg.rise_slow});
   assign prod = dp * dr;
   assign qs   = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
   assign rsum = qs + (NUM_W+1)'(t_ff);

   assign diff   = $signed({2'b00, ADC_BITS'(smp_ff), {FRACTION_BITS{1'b0}}})
                 - $signed({2'b00, acc_ff});
   // truncation toward zero of diff / 2^F
   assign dwhole = (ADC_BITS+2)'(diff[ACC_W+1] ?
                   -((-diff) >>> FRACTION_BITS) : (diff >>> FRACTION_BITS));
   assign divsel = (dwhole > 0) ? rise_ff : cfg.fall;
   assign newacc = (ACC_W+3)'($signed({3'b000, acc_ff}) + rsum);
   assign xm1    = $signed({1'b0, acc_ff[ACC_W-1:FRACTION_BITS]}) - (ADC_BITS+1)'(1);
   assign span_o = $signed({1'b0, cfg.out_max}) - $signed({1'b0, cfg.out_min});
   assign lprod  = xm1 * span_o;
   assign lmul   = q_ff[LN_W-1:0] * RECIP;

   always_comb begin
      st_in = st_ff; smp_in = smp_ff; per_in = per_ff; acc_in = acc_ff;
      rise_in = rise_ff; t_in = t_ff; neg_in = neg_ff; q_in = q_ff; r_in = r_ff;
      den_in = den_ff; cnt_in = cnt_ff; lvl_in = lvl_ff;
      case (st_ff)
         S_IDLE: if (tick_valid) begin
            smp_in = tick.sample; per_in = tick.period; st_in = S_RMUL;
         end
         S_RMUL: begin
            if (dpp == 0) begin
               t_in = $signed({3'b000, cfg.rise_slow}); neg_in = 1'b0;
               q_in = '0; st_in = S_ADJ;
               // equal periods: a zero rise divisor is raised to 1 here, not in the divider path
               rise_in = (cfg.rise_slow == '0) ? 16'd1 : cfg.rise_slow;
            end else begin
               neg_in = prod[$high(prod)] ^ dpp[$high(dpp)];
               q_in   = NUM_W'(prod[$high(prod)] ? -prod : prod);
               den_in = DEN_W'(dpp[$high(dpp)] ? -dpp : dpp);
               r_in = '0; cnt_in = CW'(NUM_W);
               t_in = $signed({3'b000, cfg.rise_slow});
               st_in = S_RDIV;
            end
         end
         S_RDIV, S_ADIV: begin
            if (cnt_ff != '0) begin
               if (!r_sub[DEN_W]) begin
                  r_in = r_sub; q_in = {q_ff[NUM_W-2:0], 1'b1};
               end else begin
                  r_in = r_sh;  q_in = {q_ff[NUM_W-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 1'b1;
            end else if (st_ff == S_RDIV) begin
               if (rsum < 1) rise_in = 16'd1;
               else if (rsum > 65535) rise_in = 16'hFFFF;
               else rise_in = rsum[msatr_pkg::DIV_W-1:0];
               st_in = S_ADJ;
            end else begin
               if (newacc < 0) acc_in = '0;
               else if (newacc > $signed({3'b000, {ACC_W{1'b1}}})) acc_in = '1;
               else acc_in = newacc[ACC_W-1:0];
               st_in = S_LMAP;
            end
         end
         S_ADJ: begin
            neg_in = dwhole[ADC_BITS+1];
            q_in   = NUM_W'(dwhole[ADC_BITS+1] ? -dwhole : dwhole) << FRACTION_BITS;
            den_in = DEN_W'((divsel == '0) ? 16'd1 : divsel);
            r_in = '0; cnt_in = CW'(NUM_W); t_in = '0;
            st_in = S_ADIV;
         end
         S_LMAP: begin
            neg_in = lprod[$high(lprod)];
            q_in   = NUM_W'(lprod[$high(lprod)] ? -lprod : lprod);
            cnt_in = CW'(1);
            t_in = $signed({9'd0, cfg.out_min});
            st_in = S_LDIV;
         end
         S_LDIV: begin
            // first step: quotient by reciprocal product, then offset and clamp
            if (cnt_ff != '0) begin
               q_in   = NUM_W'(lmul[LN_W+RM_W-1:RK]);
               cnt_in = '0;
            end else begin
               if (rsum < 0) lvl_in = '0;
               else if (rsum > 1023) lvl_in = '1;
               else lvl_in = rsum[msatr_pkg::LEVEL_W-1:0];
               st_in = S_OUT;
            end
         end
         S_OUT: if (res_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         acc_ff <= '0;
      end else begin
         st_ff  <= st_in;
         acc_ff <= acc_in;
      end
      smp_ff <= smp_in; per_ff <= per_in; rise_ff <= rise_in; t_ff <= t_in;
      neg_ff <= neg_in; q_ff <= q_in; r_ff <= r_in; den_ff <= den_in;
      cnt_ff <= cnt_in; lvl_ff <= lvl_in;
   end
endmodule
